// ===== design/lbc_pkg.sv =====
// lbc_pkg: shared constants for the LED blink controller.
// Operation, status and configuration register codes, field widths, defaults.
// No dependencies.
`default_nettype none

package lbc_pkg;

  // Field widths of the channel payloads
  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int FIELD_W = 32;
  localparam int MASK_W  = 4;
  localparam int STAT_W  = 2;

  // Parameter defaults
  localparam int LED_COUNT_DEF = 4;
  localparam int TIME_BITS_DEF = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_BLINK = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_OPEN = 2'd1;
  localparam logic [STAT_W-1:0] ST_PARAM    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_BLINK = 2'd3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPANDER = 2'd2;

endpackage

`default_nettype wire

// ===== design/lbc_intf.sv =====
// lbc_intf: valid/ready channel interfaces for the LED blink controller.
// Command beat in, result beat out. Depends on lbc_pkg.
`default_nettype none

interface lbc_in_if import lbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   led_index;
  logic               level;
  logic [FIELD_W-1:0] on_time;
  logic [FIELD_W-1:0] off_time;
  logic [FIELD_W-1:0] duration;
  logic [FIELD_W-1:0] now_time;

  modport source (output valid, operation, led_index, level, on_time, off_time,
                  duration, now_time, input ready);
  modport sink   (input valid, operation, led_index, level, on_time, off_time,
                  duration, now_time, output ready);
endinterface

interface lbc_out_if import lbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] pin_levels;
  logic [MASK_W-1:0] lit_mask;
  logic [MASK_W-1:0] blink_mask;
  logic [STAT_W-1:0] status;

  modport source (output valid, pin_levels, lit_mask, blink_mask, status, input ready);
  modport sink   (input valid, pin_levels, lit_mask, blink_mask, status, output ready);
endinterface

`default_nettype wire

// ===== design/led_blink_controller_top.sv =====
// led_blink_controller_top: multi-channel LED blink controller with polarity.
// One shared subtractor serves the cycle-count divider and the tick compares.
// Depends on lbc_pkg and the interfaces in lbc_intf.
//
//   channel | dir | beat contents
//   --------+-----+-------------------------------------------------------------
//   in_ch   | in  | operation, led_index, level, on/off time, duration, now
//   out_ch  | out | pin_levels, lit_mask, blink_mask, status
//   cfg_*   | in  | write enable, register index, data (no handshake)
//
// Sequencer steps per beat, from accept to the next accept:
// set level, rejects and closed-device beats: finish only.
// Start blink: the radix-2 divider (one bit a cycle), then load, then finish.
// Tick: a subtract per channel, plus a compare for each blinking one, then finish.
// in_ch.ready is high only while the sequencer is idle; the output register
// lets a new beat in while the previous result still waits on out_ch.ready.
// Reset (rst_n low, synchronous) clears the sequencer, blink and lit state.
`default_nettype none

module led_blink_controller_top import lbc_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lbc_in_if.sink                     in_ch,
  lbc_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TB   = TIME_BITS;
  localparam int SW   = TB + 2;
  localparam int IW   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int SCW  = $clog2(TB);
  localparam logic [IW-1:0]  LAST_CH   = IW'(LED_COUNT - 1);
  localparam logic [SCW-1:0] LAST_STEP = SCW'(TB - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_TSUB = 3'd3;
  localparam logic [2:0] S_TCMP = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Configuration registers
  logic              open_r;
  logic [MASK_W-1:0] act_low_r;
  logic [MASK_W-1:0] expander_r;

  // Per-channel state
  logic          blinking_r [LED_COUNT];
  logic          lit_r      [LED_COUNT];
  logic [TB-1:0] cl_r       [LED_COUNT];
  logic [TB-1:0] ps_r       [LED_COUNT];
  logic [TB-1:0] on_r       [LED_COUNT];
  logic [TB-1:0] off_r      [LED_COUNT];

  // Working registers for the beat in flight
  logic [IW-1:0]     ch_r;
  logic [IW-1:0]     it_r;
  logic [TB-1:0]     now_r;
  logic [TB-1:0]     on_len_r;
  logic [TB-1:0]     off_len_r;
  logic [TB:0]       per_r;
  logic [TB:0]       rem_r;
  logic [TB-1:0]     q_r;
  logic [TB-1:0]     elapsed_r;
  logic [SCW-1:0]    step_r;
  logic [STAT_W-1:0] status_r;

  // Output register
  logic              out_valid_r;
  logic [MASK_W-1:0] pins_r, litm_r, blinkm_r;
  logic [STAT_W-1:0] out_status_r;

  // Accept decode
  logic              accept;
  logic              in_range;
  logic              exp_bit;
  logic              do_set;
  logic [STAT_W-1:0] acc_status;
  logic [2:0]        acc_state;
  logic [IW-1:0]     acc_ch;
  logic [TB-1:0]     in_on, in_off, in_dur, in_now;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_on       = in_ch.on_time[TB-1:0];
  assign in_off      = in_ch.off_time[TB-1:0];
  assign in_dur      = in_ch.duration[TB-1:0];
  assign in_now      = in_ch.now_time[TB-1:0];
  assign acc_ch      = in_ch.led_index[IW-1:0];
  assign in_range    = ({1'b0, in_ch.led_index} < (IDX_W + 1)'(LED_COUNT));
  assign exp_bit     = (in_ch.led_index < IDX_W'(MASK_W)) &&
                       expander_r[in_ch.led_index[1:0]];

  // Command decode: status and the sequencer's first step
  always_comb begin
    acc_status = ST_OK;
    acc_state  = S_FIN;
    do_set     = 1'b0;
    if (!open_r) begin
      acc_status = ST_NOT_OPEN;
    end else begin
      unique case (in_ch.operation)
        OP_TICK: begin
          acc_state = S_TSUB;
        end
        OP_SET: begin
          if (!in_range) acc_status = ST_PARAM;
          else do_set = 1'b1;
        end
        OP_BLINK: begin
          if (!in_range) acc_status = ST_PARAM;
          else if (in_on == '0 && in_off == '0) acc_status = ST_PARAM;
          else if (exp_bit) acc_status = ST_NO_BLINK;
          else if (in_dur == '0) acc_status = ST_PARAM;
          else begin
            acc_state = S_DIV;
          end
        end
        default: acc_status = ST_PARAM;
      endcase
    end
  end

  // Shared subtractor: divider trial, elapsed time, phase length compare
  logic [SW-1:0] sub_a, sub_b;
  logic [SW:0]   sub_diff;
  logic          sub_ge;
  logic [TB-1:0] cur_len;

  assign cur_len = lit_r[it_r] ? on_r[it_r] : off_r[it_r];

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_r)
      S_DIV: begin
        sub_a = {rem_r, q_r[TB-1]};
        sub_b = {1'b0, per_r};
      end
      S_TSUB: begin
        sub_a = {2'b00, now_r};
        sub_b = {2'b00, ps_r[it_r]};
      end
      S_TCMP: begin
        sub_a = {2'b00, elapsed_r};
        sub_b = {2'b00, cur_len};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[SW];

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = acc_state;
      S_DIV:  if (step_r == '0) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_FIN;
      S_TSUB: begin
        if (blinking_r[it_r]) state_nxt = S_TCMP;
        else if (it_r == LAST_CH) state_nxt = S_FIN;
      end
      S_TCMP: state_nxt = (it_r == LAST_CH) ? S_FIN : S_TSUB;
      S_FIN:  if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      act_low_r  <= 4'hF;
      expander_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPEN:     open_r     <= cfg_wdata[0];
        CFG_ACT_LOW:  act_low_r  <= cfg_wdata;
        CFG_EXPANDER: expander_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Working registers and divider datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r      <= acc_ch;
      now_r     <= in_now;
      on_len_r  <= in_on;
      off_len_r <= in_off;
      per_r     <= {1'b0, in_on} + {1'b0, in_off};
      q_r       <= in_dur - TB'(1);
      rem_r     <= '0;
      step_r    <= LAST_STEP;
      it_r      <= '0;
      status_r  <= acc_status;
    end else begin
      unique case (state_r)
        S_DIV: begin
          rem_r  <= sub_ge ? sub_diff[TB:0] : sub_a[TB:0];
          q_r    <= {q_r[TB-2:0], sub_ge};
          step_r <= step_r - SCW'(1);
        end
        S_TSUB: begin
          elapsed_r <= sub_diff[TB-1:0];
          if (!blinking_r[it_r] && it_r != LAST_CH) it_r <= it_r + IW'(1);
        end
        S_TCMP: begin
          if (it_r != LAST_CH) it_r <= it_r + IW'(1);
        end
        default: ;
      endcase
    end
  end

  // Channel state: config open change, set level, blink load, tick update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        blinking_r[i] <= 1'b0;
        lit_r[i]      <= 1'b0;
      end
    end else if (cfg_we && cfg_index == CFG_OPEN && cfg_wdata[0] != open_r) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        blinking_r[i] <= 1'b0;
        lit_r[i]      <= 1'b0;
      end
    end else if (accept) begin
      if (do_set) begin
        blinking_r[acc_ch] <= 1'b0;
        lit_r[acc_ch]      <= in_ch.level;
      end
    end else if (state_r == S_LOAD) begin
      lit_r[ch_r]      <= 1'b1;
      blinking_r[ch_r] <= 1'b1;
      cl_r[ch_r]       <= q_r + TB'(1);
      on_r[ch_r]       <= on_len_r;
      off_r[ch_r]      <= off_len_r;
      ps_r[ch_r]       <= now_r;
    end else if (state_r == S_TCMP && sub_ge) begin
      lit_r[it_r] <= !lit_r[it_r];
      ps_r[it_r]  <= now_r;
      if (lit_r[it_r]) begin
        // end of a lit phase: one cycle finished
        if (cl_r[it_r] != '0) cl_r[it_r] <= cl_r[it_r] - TB'(1);
        if (cl_r[it_r] <= TB'(1)) blinking_r[it_r] <= 1'b0;
      end
    end
  end

  // Result snapshot of the channel state
  logic [MASK_W-1:0] lit_vec, blink_vec, pin_vec;

  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < LED_COUNT) begin : g_used
      assign lit_vec[g]   = lit_r[g];
      assign blink_vec[g] = blinking_r[g];
      assign pin_vec[g]   = lit_r[g] ^ act_low_r[g];
    end else begin : g_unused
      assign lit_vec[g]   = 1'b0;
      assign blink_vec[g] = 1'b0;
      assign pin_vec[g]   = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
      pins_r       <= pin_vec;
      litm_r       <= lit_vec;
      blinkm_r     <= blink_vec;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pin_levels = pins_r;
  assign out_ch.lit_mask   = litm_r;
  assign out_ch.blink_mask = blinkm_r;
  assign out_ch.status     = out_status_r;

`ifndef SYNTHESIS
  // Blinking channel 0 always has at least one blink cycle left
  a_blink_has_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    blinking_r[0] |-> (cl_r[0] != '0))
    else $error("channel 0 blinking with zero cycles left");

  // Checks that a closed device never has channel 0 blinking
  a_closed_no_blink: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> !blinking_r[0])
    else $error("blink active while device closed");

  // Divider step counter ends the division after TIME_BITS steps
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == '0) |=> (state_r == S_LOAD))
    else $error("divider did not hand over to load");
`endif

endmodule

`default_nettype wire

// ===== tb/led_blink_controller_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for led_blink_controller_top: directed and random command
// beats, a channel-state tracker predicts each result beat. Needs lbc_pkg and lbc_intf.

module led_blink_controller_top_tb import lbc_pkg::*; ();

  localparam int NCH          = LED_COUNT_DEF;
  localparam int LIMIT_CYCLES = 800_000;
  localparam int SETTLE_CYCLES = 48;     // longer than the slowest command (start blink)
  localparam int HOLD_CYCLES  = 400;
  localparam int NUM_SEGS     = 6;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   idx;
    logic               level;
    logic [FIELD_W-1:0] on_t;
    logic [FIELD_W-1:0] off_t;
    logic [FIELD_W-1:0] dur;
    logic [FIELD_W-1:0] now_t;
  } led_cmd_t;

  typedef struct {
    logic [MASK_W-1:0] pins;
    logic [MASK_W-1:0] lit;
    logic [MASK_W-1:0] blink;
    logic [STAT_W-1:0] status;
  } led_view_t;

  // Tracks the channel state and the queue of result beats still owed
  class led_state_tracker;
    bit                 dev_open;
    logic [MASK_W-1:0]  act_low;
    logic [MASK_W-1:0]  expander;
    bit                 blinking [NCH];
    bit                 lit [NCH];
    logic [FIELD_W-1:0] cycles_left [NCH];
    logic [FIELD_W-1:0] phase_start [NCH];
    logic [FIELD_W-1:0] on_len [NCH];
    logic [FIELD_W-1:0] off_len [NCH];
    led_view_t          owed_views [$];
    int                 mismatches;

    function new();
      dev_open   = 1'b0;
      act_low    = 4'hF;
      expander   = 4'h0;
      mismatches = 0;
      for (int ch = 0; ch < NCH; ch++) begin
        blinking[ch]    = 1'b0;
        lit[ch]         = 1'b0;
        cycles_left[ch] = '0;
        phase_start[ch] = '0;
        on_len[ch]      = '0;
        off_len[ch]     = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_OPEN) begin
        // any change of open state drops blink and lit on all channels
        if (data[0] != dev_open) begin
          for (int ch = 0; ch < NCH; ch++) begin
            blinking[ch] = 1'b0;
            lit[ch]      = 1'b0;
          end
        end
        dev_open = data[0];
      end else if (idx == CFG_ACT_LOW) begin
        act_low = data[MASK_W-1:0];
      end else if (idx == CFG_EXPANDER) begin
        expander = data[MASK_W-1:0];
      end
    endfunction

    function void note_command(led_cmd_t c);
      led_view_t          v;
      logic [FIELD_W:0]   period;
      logic [FIELD_W:0]   count;
      logic [FIELD_W-1:0] elapsed;
      v.status = ST_OK;
      if (!dev_open) begin
        v.status = ST_NOT_OPEN;
      end else if (c.op == OP_TICK) begin
        // advance every blinking channel against its current phase length
        for (int ch = 0; ch < NCH; ch++) begin
          if (blinking[ch]) begin
            elapsed = c.now_t - phase_start[ch];
            if (!lit[ch]) begin
              if (elapsed >= off_len[ch]) begin
                lit[ch]         = 1'b1;
                phase_start[ch] = c.now_t;
              end
            end else if (elapsed >= on_len[ch]) begin
              lit[ch]         = 1'b0;
              phase_start[ch] = c.now_t;
              if (cycles_left[ch] != 0) cycles_left[ch] = cycles_left[ch] - 1;
              if (cycles_left[ch] == 0) blinking[ch] = 1'b0;
            end
          end
        end
      end else if (c.op == OP_UNUSED) begin
        v.status = ST_PARAM;
      end else if (c.idx >= NCH) begin
        v.status = ST_PARAM;
      end else if (c.op == OP_SET) begin
        blinking[c.idx] = 1'b0;
        lit[c.idx]      = c.level;
      end else if (c.on_t == 0 && c.off_t == 0) begin
        v.status = ST_PARAM;
      end else if (expander[c.idx]) begin
        v.status = ST_NO_BLINK;
      end else begin
        // ceil(duration / period) with a period one bit wider than time
        period = {1'b0, c.on_t} + {1'b0, c.off_t};
        count  = (c.dur == 0) ? '0 : ({1'b0, c.dur} - 1'b1) / period + 1'b1;
        if (count == 0) begin
          v.status = ST_PARAM;
        end else begin
          lit[c.idx]         = 1'b1;
          cycles_left[c.idx] = count[FIELD_W-1:0];
          on_len[c.idx]      = c.on_t;
          off_len[c.idx]     = c.off_t;
          phase_start[c.idx] = c.now_t;
          blinking[c.idx]    = 1'b1;
        end
      end
      for (int ch = 0; ch < MASK_W; ch++) begin
        v.lit[ch]   = lit[ch];
        v.pins[ch]  = lit[ch] ^ act_low[ch];
        v.blink[ch] = blinking[ch];
      end
      owed_views.push_back(v);
    endfunction

    function void check_result(led_view_t got);
      led_view_t want;
      if (owed_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: pins=%h lit=%h blink=%h status=%0d",
                   got.pins, got.lit, got.blink, got.status);
        return;
      end
      want = owed_views.pop_front();
      if (got.pins !== want.pins || got.lit !== want.lit ||
          got.blink !== want.blink || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: exp pins=%h lit=%h blink=%h status=%0d,",
                    " got pins=%h lit=%h blink=%h status=%0d"},
                   want.pins, want.lit, want.blink, want.status,
                   got.pins, got.lit, got.blink, got.status);
      end
    endfunction

    function int outstanding();
      return owed_views.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lbc_in_if  in_ch ();
  lbc_out_if out_ch ();

  led_state_tracker tracker;
  logic [FIELD_W-1:0] wall_clock;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int          hold_requests;
  int          hold_taken = 0;
  int          hold_left = 0;
  int          cycle_count = 0;

  led_blink_controller_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result sink: random back-pressure plus requested long hold-offs
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_taken != hold_requests) begin
      hold_taken   <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    led_view_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.pins   = out_ch.pin_levels;
      got.lit    = out_ch.lit_mask;
      got.blink  = out_ch.blink_mask;
      got.status = out_ch.status;
      tracker.check_result(got);
    end
  end

  function automatic led_cmd_t build_cmd(logic [OP_W-1:0] op, int idx,
                                         int level, logic [FIELD_W-1:0] on_t,
                                         logic [FIELD_W-1:0] off_t,
                                         logic [FIELD_W-1:0] dur,
                                         logic [FIELD_W-1:0] now_t);
    led_cmd_t c;
    c.op    = op;
    c.idx   = IDX_W'(idx);
    c.level = 1'(level);
    c.on_t  = on_t;
    c.off_t = off_t;
    c.dur   = dur;
    c.now_t = now_t;
    return c;
  endfunction

  // Mostly small, coherent blink traffic on a running clock; some noise
  function automatic led_cmd_t random_command();
    led_cmd_t    c;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    c.op    = OP_TICK;
    c.idx   = IDX_W'($urandom_range(0, NCH - 1));
    c.level = 1'($urandom_range(0, 1));
    c.on_t  = $urandom_range(0, 12);
    c.off_t = $urandom_range(0, 12);
    c.dur   = $urandom_range(0, 60);
    if (pick < 45) begin
      // time jumps now and then, backward jumps included
      if ($urandom_range(0, 19) == 0) wall_clock = $urandom();
      else wall_clock = wall_clock + $urandom_range(0, 6);
      c.on_t  = $urandom();
      c.off_t = $urandom();
      c.dur   = $urandom();
    end else if (pick < 72) begin
      c.op = OP_BLINK;
      if ($urandom_range(0, 9) == 0) begin
        c.on_t  = $urandom();
        c.off_t = $urandom();
        c.dur   = $urandom();
      end
      if ($urandom_range(0, 14) == 0) c.idx = IDX_W'($urandom_range(0, 15));
    end else if (pick < 87) begin
      c.op = OP_SET;
      if ($urandom_range(0, 9) == 0) c.idx = IDX_W'($urandom_range(NCH, 15));
    end else if (pick < 92) begin
      c.op = OP_UNUSED;
    end
    c.now_t = wall_clock;
    if (pick >= 92) begin
      c.op    = OP_W'($urandom_range(0, 3));
      c.idx   = IDX_W'($urandom_range(0, 15));
      c.on_t  = $urandom();
      c.off_t = $urandom();
      c.dur   = $urandom();
      c.now_t = $urandom();
    end
    return c;
  endfunction

  // Offer one command beat, with random gaps ahead of it
  task automatic send_command(input led_cmd_t c);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= c.op;
    in_ch.led_index <= c.idx;
    in_ch.level     <= c.level;
    in_ch.on_time   <= c.on_t;
    in_ch.off_time  <= c.off_t;
    in_ch.duration  <= c.dur;
    in_ch.now_time  <= c.now_t;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    tracker.note_command(c);
  endtask

  // Stop sending and let every owed result drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [FIELD_W-1:0]    t0;
    logic [CFG_DATA_W-1:0] seg_act_low [NUM_SEGS];
    logic [CFG_DATA_W-1:0] seg_expander [NUM_SEGS];
    bit                    seg_open [NUM_SEGS];
    int                    seg_items [NUM_SEGS];

    tracker = new();
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_TICK;
    in_ch.led_index <= '0;
    in_ch.level     <= 1'b0;
    in_ch.on_time   <= '0;
    in_ch.off_time  <= '0;
    in_ch.duration  <= '0;
    in_ch.now_time  <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_OPEN;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    hold_requests   = 0;
    tx_idle_pct     = 28;
    rx_idle_pct     = 71;
    wall_clock      = 32'hFFFF_FF00 + $urandom_range(0, 255);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // closed device rejects ticks and commands
    send_command(build_cmd(OP_TICK, 0, 0, '1, '1, '1, '1));
    send_command(build_cmd(OP_SET, 2, 1, 0, 0, 0, 0));
    wait_idle();
    set_reg(CFG_OPEN, 4'b0001);
    set_reg(CFG_ACT_LOW, 4'b0101);
    set_reg(CFG_EXPANDER, 4'b1000);

    // parameter checks, expander channel, field extremes
    t0 = 32'hFFFF_FFFC;
    send_command(build_cmd(OP_SET, 0, 1, 0, 0, 0, t0));
    send_command(build_cmd(OP_SET, 15, 1, 0, 0, 0, t0));
    send_command(build_cmd(OP_UNUSED, 1, 1, 5, 5, 5, t0));
    send_command(build_cmd(OP_BLINK, 1, 0, 0, 0, 100, t0));
    send_command(build_cmd(OP_BLINK, 1, 0, 3, 2, 0, t0));
    send_command(build_cmd(OP_BLINK, 4, 0, 3, 2, 10, t0));
    send_command(build_cmd(OP_BLINK, 3, 0, 3, 2, 10, t0));
    send_command(build_cmd(OP_SET, 3, 1, 0, 0, 0, t0));
    send_command(build_cmd(OP_BLINK, 2, 1, '1, '1, '1, t0));
    send_command(build_cmd(OP_BLINK, 0, 0, 1, 0, '1, t0));
    send_command(build_cmd(OP_BLINK, 1, 0, 2, 3, 11, t0));

    // full blink cycles on channel 1 until its blink ends, crossing the time wrap
    send_command(build_cmd(OP_TICK, 0, 0, 0, 0, 0, t0 + 1));
    send_command(build_cmd(OP_TICK, 0, 0, 0, 0, 0, t0 + 2));
    send_command(build_cmd(OP_TICK, 0, 0, 0, 0, 0, t0 + 5));
    send_command(build_cmd(OP_TICK, 0, 0, 0, 0, 0, t0 + 7));
    send_command(build_cmd(OP_TICK, 0, 0, 0, 0, 0, t0 + 10));
    send_command(build_cmd(OP_TICK, 0, 0, 0, 0, 0, t0 + 12));
    // backward step gives a huge elapsed time
    send_command(build_cmd(OP_TICK, 0, 0, 0, 0, 0, t0 - 5));

    // closing while blinking clears every channel
    wait_idle();
    set_reg(CFG_OPEN, 4'b0000);
    send_command(build_cmd(OP_TICK, 0, 0, 0, 0, 0, t0));
    wait_idle();
    set_reg(CFG_OPEN, 4'b1111);
    send_command(build_cmd(OP_TICK, 0, 0, 0, 0, 0, t0));

    // random segments, each under its own register setting
    seg_act_low  = '{4'hF, 4'h0, 4'($urandom), 4'($urandom), 4'hA, 4'($urandom)};
    seg_expander = '{4'h0, 4'hF, 4'($urandom), 4'h0, 4'($urandom), 4'h0};
    seg_open     = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    seg_items    = '{320, 150, 330, 60, 420, 370};
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      wait_idle();
      if (seg < 2) begin
        tx_idle_pct = 28;
        rx_idle_pct = 71;
      end else if (seg < 4) begin
        tx_idle_pct = 71;
        rx_idle_pct = 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_reg(CFG_OPEN, {3'($urandom), seg_open[seg]});
      set_reg(CFG_ACT_LOW, seg_act_low[seg]);
      set_reg(CFG_EXPANDER, seg_expander[seg]);
      for (int n = 0; n < seg_items[seg]; n++) begin
        // long sink hold-off fills the block; later a full drain mid-stream
        if (seg == 4 && n == 60) hold_requests = hold_requests + 1;
        if (seg == 5 && n == 120) wait_idle();
        send_command(random_command());
      end
    end

    wait_idle();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
